// File: src/paged_free_list_cell_allocator_assert.svh
// Assertion macros for the allocator RTL, used by the datapath (pfl_dp).
// The asserting module must have clk and rst_n in scope.
`ifndef PAGED_FREE_LIST_CELL_ALLOCATOR_ASSERT_SVH
`define PAGED_FREE_LIST_CELL_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset
`define PFL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfl assertion failed");

// Antecedent implies consequent at the next clock edge
`define PFL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfl assertion failed");

`else

`define PFL_ASSERT(name, prop)
`define PFL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: src/pfl_pkg.sv
`timescale 1ns / 1ps

package pfl_pkg;

  // Field widths
  localparam int ADDR_W  = 11;
  localparam int TAG_W   = 32;
  localparam int PAGES_W = 4;
  localparam int CNT_W   = 32;

  // Cells 0 (NIL) and 1 (T) never go onto the list
  localparam int PINNED_CELLS = 2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_HELD = 2'd1,
    ST_PINNED   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input beat, launch the memory reads
    logic commit;   // update state, write memories, load the result
  } pfl_cmd_t;

endpackage

// File: src/pfl_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module pfl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/pfl_ctrl.sv
`timescale 1ns / 1ps

// Two-state sequencer: capture a request, then commit it once the
// result register is free.
module pfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pfl_pkg::pfl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Handshake decode
  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on commit, held while the receiver stalls
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/pfl_dp.sv
`timescale 1ns / 1ps

`include "paged_free_list_cell_allocator_assert.svh"

// Datapath: list registers, cell memories and result register.
// Cells of the newest page that were never popped form the tail of the
// list; they are tracked by a descending window (fresh_low..fresh_top)
// instead of memory contents, so bringing up a page costs no walk.
module pfl_dp #(
  parameter int PAGE_COUNT     = 8,
  parameter int CELLS_PER_PAGE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfl_pkg::pfl_cmd_t            cmd_i,
  input  logic                         in_op,
  input  logic [pfl_pkg::TAG_W-1:0]    in_cell_tag_in,
  input  logic [pfl_pkg::ADDR_W-1:0]   in_cell_to_free,
  output logic [pfl_pkg::ADDR_W-1:0]   out_cell_address,
  output logic [1:0]                   out_status,
  output logic [pfl_pkg::TAG_W-1:0]    out_freed_tag,
  output logic [pfl_pkg::PAGES_W-1:0]  out_pages_in_use,
  output logic [pfl_pkg::CNT_W-1:0]    out_allocated_total,
  output logic [pfl_pkg::CNT_W-1:0]    out_freed_total
);

  localparam int TOTAL = PAGE_COUNT * CELLS_PER_PAGE;
  localparam int CW    = $clog2(TOTAL);
  localparam int LW    = CW + 1;
  localparam int PW    = $clog2(PAGE_COUNT + 1);
  localparam int AddrW = pfl_pkg::ADDR_W;
  localparam int PagesW = pfl_pkg::PAGES_W;

  // List state
  logic [CW-1:0] head_r, head_nxt;
  logic          list_empty_r, list_empty_nxt;
  logic [CW-1:0] fresh_top_r, fresh_top_nxt;
  logic [CW-1:0] fresh_low_r, fresh_low_nxt;
  logic          fresh_any_r, fresh_any_nxt;
  logic [LW-1:0] up_limit_r, up_limit_nxt;
  logic [PW-1:0] page_count_r, page_count_nxt;
  logic [pfl_pkg::CNT_W-1:0] alloc_cnt_r, alloc_cnt_nxt;
  logic [pfl_pkg::CNT_W-1:0] free_cnt_r, free_cnt_nxt;

  // Captured request
  logic                        op_r;
  logic [pfl_pkg::TAG_W-1:0]   tag_r;
  logic [pfl_pkg::ADDR_W-1:0]  addr_r;
  logic [CW-1:0]               idx_r;
  logic                        in_range_r;
  logic                        pinned_r;

  // Result register
  logic [pfl_pkg::ADDR_W-1:0]  cell_address_r, cell_address_nxt;
  pfl_pkg::status_t            status_r, status_nxt;
  logic [pfl_pkg::TAG_W-1:0]   freed_tag_r, freed_tag_nxt;

  // Memory ports
  logic [CW-1:0]             rd_addr;
  logic [CW-1:0]             wr_addr;
  logic [0:0]                free_rd;
  logic [CW-1:0]             link_rd;
  logic [pfl_pkg::TAG_W-1:0] tag_rd;
  logic                      free_we, link_we, tag_we;
  logic [0:0]                free_wd;
  logic [CW-1:0]             link_wd;

  // Decode
  logic          in_range;
  logic          bring_up;
  logic          alloc_ok;
  logic          pop_fresh;
  logic [CW-1:0] new_top;
  logic [CW-1:0] pop_addr;
  logic [CW-1:0] cur_low;
  logic          pop_last;
  logic [CW-1:0] pop_next;
  logic          untouched;
  logic          is_free;
  logic          free_ok;

  // Read at the cell named by the request, or at the list head
  assign rd_addr  = (in_op == pfl_pkg::OP_FREE) ? CW'(in_cell_to_free) : head_r;
  assign in_range = 32'(in_cell_to_free) < 32'(up_limit_r);

  // Allocate path
  always_comb begin
    bring_up  = (op_r == pfl_pkg::OP_ALLOC) && list_empty_r &&
                (page_count_r != PW'(PAGE_COUNT));
    alloc_ok  = (op_r == pfl_pkg::OP_ALLOC) && (!list_empty_r || bring_up);
    new_top   = CW'(up_limit_r + LW'(CELLS_PER_PAGE - 1));
    pop_fresh = bring_up || (fresh_any_r && (head_r == fresh_top_r));
    pop_addr  = bring_up ? new_top : head_r;
    cur_low   = bring_up ? CW'(up_limit_r) : fresh_low_r;
    pop_last  = pop_fresh ? (pop_addr == cur_low) : (link_rd == '0);
    pop_next  = pop_fresh ? (pop_addr - CW'(1)) : link_rd;
  end

  // Free path
  always_comb begin
    untouched = fresh_any_r && (idx_r >= fresh_low_r) && (idx_r <= fresh_top_r);
    is_free   = untouched ? 1'b1 : free_rd[0];
    free_ok   = (op_r == pfl_pkg::OP_FREE) && !pinned_r && in_range_r && !is_free;
  end

  // State update and result
  always_comb begin
    head_nxt         = head_r;
    list_empty_nxt   = list_empty_r;
    fresh_top_nxt    = fresh_top_r;
    fresh_low_nxt    = fresh_low_r;
    fresh_any_nxt    = fresh_any_r;
    up_limit_nxt     = up_limit_r;
    page_count_nxt   = page_count_r;
    alloc_cnt_nxt    = alloc_cnt_r;
    free_cnt_nxt     = free_cnt_r;
    cell_address_nxt = '0;
    status_nxt       = pfl_pkg::ST_OK;
    freed_tag_nxt    = '0;

    if (op_r == pfl_pkg::OP_ALLOC) begin
      if (alloc_ok) begin
        cell_address_nxt = AddrW'(pop_addr);
        alloc_cnt_nxt    = alloc_cnt_r + 1'b1;
        list_empty_nxt   = pop_last;
        if (!pop_last) begin
          head_nxt = pop_next;
        end
        if (pop_fresh) begin
          fresh_top_nxt = pop_addr - CW'(1);
          fresh_low_nxt = cur_low;
          fresh_any_nxt = !pop_last;
        end
        if (bring_up) begin
          page_count_nxt = page_count_r + 1'b1;
          up_limit_nxt   = up_limit_r + LW'(CELLS_PER_PAGE);
        end
      end else begin
        status_nxt = pfl_pkg::ST_FULL;
      end
    end else begin
      cell_address_nxt = addr_r;
      if (pinned_r) begin
        status_nxt = pfl_pkg::ST_PINNED;
      end else if (!free_ok) begin
        status_nxt = pfl_pkg::ST_NOT_HELD;
      end else begin
        freed_tag_nxt  = tag_rd;
        head_nxt       = idx_r;
        list_empty_nxt = 1'b0;
        free_cnt_nxt   = free_cnt_r + 1'b1;
      end
    end
  end

  // Memory writes
  always_comb begin
    wr_addr = (op_r == pfl_pkg::OP_ALLOC) ? pop_addr : idx_r;
    free_we = cmd_i.commit && (alloc_ok || free_ok);
    free_wd = (op_r == pfl_pkg::OP_FREE) ? 1'b1 : 1'b0;
    link_we = cmd_i.commit && free_ok;
    link_wd = list_empty_r ? '0 : head_r;
    tag_we  = cmd_i.commit && alloc_ok;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= CW'(CELLS_PER_PAGE - 1);
      list_empty_r <= 1'b0;
      fresh_top_r  <= CW'(CELLS_PER_PAGE - 1);
      fresh_low_r  <= CW'(pfl_pkg::PINNED_CELLS);
      fresh_any_r  <= 1'b1;
      up_limit_r   <= LW'(CELLS_PER_PAGE);
      page_count_r <= PW'(1);
      alloc_cnt_r  <= '0;
      free_cnt_r   <= '0;
    end else if (cmd_i.commit) begin
      head_r       <= head_nxt;
      list_empty_r <= list_empty_nxt;
      fresh_top_r  <= fresh_top_nxt;
      fresh_low_r  <= fresh_low_nxt;
      fresh_any_r  <= fresh_any_nxt;
      up_limit_r   <= up_limit_nxt;
      page_count_r <= page_count_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      free_cnt_r   <= free_cnt_nxt;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r       <= in_op;
      tag_r      <= in_cell_tag_in;
      addr_r     <= in_cell_to_free;
      idx_r      <= CW'(in_cell_to_free);
      in_range_r <= in_range;
      pinned_r   <= in_cell_to_free < AddrW'(pfl_pkg::PINNED_CELLS);
    end
    if (cmd_i.commit) begin
      cell_address_r <= cell_address_nxt;
      status_r       <= status_nxt;
      freed_tag_r    <= freed_tag_nxt;
    end
  end

  // Cell memories
  pfl_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (wr_addr),
    .wdata (free_wd),
    .re    (cmd_i.capture),
    .raddr (rd_addr),
    .rdata (free_rd)
  );

  pfl_ram #(.WIDTH(CW), .DEPTH(TOTAL)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (wr_addr),
    .wdata (link_wd),
    .re    (cmd_i.capture),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  pfl_ram #(.WIDTH(pfl_pkg::TAG_W), .DEPTH(TOTAL)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_addr),
    .wdata (tag_r),
    .re    (cmd_i.capture),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  assign out_cell_address    = cell_address_r;
  assign out_status          = status_r;
  assign out_freed_tag       = freed_tag_r;
  assign out_pages_in_use    = PagesW'(page_count_r);
  assign out_allocated_total = alloc_cnt_r;
  assign out_freed_total     = free_cnt_r;

  // The untouched window is the tail of the list, so it is gone when the list is empty
  `PFL_ASSERT(a_empty_no_fresh, !(list_empty_r && fresh_any_r))
  // Window lies inside the pages brought up
  `PFL_ASSERT(a_fresh_bounds,
    !fresh_any_r || ((fresh_top_r >= fresh_low_r) && (LW'(fresh_top_r) < up_limit_r)))
  // Head never names a pinned cell or a cell beyond the pages brought up
  `PFL_ASSERT(a_head_bounds,
    list_empty_r || ((head_r >= CW'(pfl_pkg::PINNED_CELLS)) && (LW'(head_r) < up_limit_r)))
  // A new page leaves untouched cells behind the popped one
  `PFL_ASSERT_NEXT(a_bring_up_fills, cmd_i.commit && bring_up, fresh_any_r && !list_empty_r)

endmodule

// File: src/paged_free_list_cell_allocator.sv
`timescale 1ns / 1ps

// Paged free-list cell allocator.
// Input channel (in_valid / in_stall): in_op selects allocate or free;
// allocate pops the list head and stores in_cell_tag_in there, free pushes
// in_cell_to_free back. Result channel (out_valid / out_stall): one result
// beat per request with the cell address, status, freed tag and the
// running page and allocate/free totals.
// The request beat is captured with the cell memory reads launched; the
// result register is loaded on commit, once it is free.
// The input is stalled until each request is committed: the memory reads
// start at capture, the execute state does the read-modify-write, and
// the head pointer of one request is needed to address the next.
// An allocate on an empty list brings a page up: its never-used cells are
// tracked by a descending window, so no walk over the page is made.
// Reset: page 0 is up, cells 0 and 1 pinned, cells 2 and up free with the
// highest at the head; no clearing pass, requests are taken right away.
// A stalled result holds its payload; the block takes one more request
// and then stalls the input until the result register is free.
module paged_free_list_cell_allocator #(
  parameter int PAGE_COUNT     = 8,
  parameter int CELLS_PER_PAGE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [pfl_pkg::TAG_W-1:0]    in_cell_tag_in,
  input  logic [pfl_pkg::ADDR_W-1:0]   in_cell_to_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pfl_pkg::ADDR_W-1:0]   out_cell_address,
  output logic [1:0]                   out_status,
  output logic [pfl_pkg::TAG_W-1:0]    out_freed_tag,
  output logic [pfl_pkg::PAGES_W-1:0]  out_pages_in_use,
  output logic [pfl_pkg::CNT_W-1:0]    out_allocated_total,
  output logic [pfl_pkg::CNT_W-1:0]    out_freed_total
);

  pfl_pkg::pfl_cmd_t cmd;

  // Sequencer
  pfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // List state, memories and result register
  pfl_dp #(
    .PAGE_COUNT     (PAGE_COUNT),
    .CELLS_PER_PAGE (CELLS_PER_PAGE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_i               (cmd),
    .in_op               (in_op),
    .in_cell_tag_in      (in_cell_tag_in),
    .in_cell_to_free     (in_cell_to_free),
    .out_cell_address    (out_cell_address),
    .out_status          (out_status),
    .out_freed_tag       (out_freed_tag),
    .out_pages_in_use    (out_pages_in_use),
    .out_allocated_total (out_allocated_total),
    .out_freed_total     (out_freed_total)
  );

endmodule

// File: sim/tb_paged_free_list_cell_allocator.sv
`timescale 1ns / 1ps

module tb_paged_free_list_cell_allocator;

  localparam int PAGES       = 8;
  localparam int PAGE_CELLS  = 256;
  localparam int ALL_CELLS   = PAGES * PAGE_CELLS;
  localparam int QUIET_LIMIT = 2000;
  localparam int BATCH       = 20;

  typedef struct packed {
    logic                       op;
    logic [pfl_pkg::TAG_W-1:0]  tag;
    logic [pfl_pkg::ADDR_W-1:0] addr;
  } cell_request_t;

  typedef struct packed {
    logic [pfl_pkg::ADDR_W-1:0]  addr;
    pfl_pkg::status_t            status;
    logic [pfl_pkg::TAG_W-1:0]   tag;
    logic [pfl_pkg::PAGES_W-1:0] pages;
    logic [pfl_pkg::CNT_W-1:0]   allocs;
    logic [pfl_pkg::CNT_W-1:0]   frees;
  } cell_result_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                        clk;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic                        in_op           = pfl_pkg::OP_ALLOC;
  logic [pfl_pkg::TAG_W-1:0]   in_cell_tag_in  = '0;
  logic [pfl_pkg::ADDR_W-1:0]  in_cell_to_free = '0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic [pfl_pkg::ADDR_W-1:0]  out_cell_address;
  logic [1:0]                  out_status;
  logic [pfl_pkg::TAG_W-1:0]   out_freed_tag;
  logic [pfl_pkg::PAGES_W-1:0] out_pages_in_use;
  logic [pfl_pkg::CNT_W-1:0]   out_allocated_total;
  logic [pfl_pkg::CNT_W-1:0]   out_freed_total;

  paged_free_list_cell_allocator #(
    .PAGE_COUNT     (PAGES),
    .CELLS_PER_PAGE (PAGE_CELLS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_cell_tag_in      (in_cell_tag_in),
    .in_cell_to_free     (in_cell_to_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_address    (out_cell_address),
    .out_status          (out_status),
    .out_freed_tag       (out_freed_tag),
    .out_pages_in_use    (out_pages_in_use),
    .out_allocated_total (out_allocated_total),
    .out_freed_total     (out_freed_total)
  );

  // Stimulus and scoreboard storage
  cell_request_t pending_requests[$];
  cell_result_t  cell_results_due[$];
  cell_request_t next_request;

  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int batch_no      = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // Allocator shadow state
  logic                       shadow_free [ALL_CELLS];
  logic [pfl_pkg::ADDR_W-1:0] shadow_link [ALL_CELLS];
  logic [pfl_pkg::TAG_W-1:0]  shadow_tag  [ALL_CELLS];
  logic [pfl_pkg::ADDR_W-1:0] head_cell;
  logic                       chain_dry;
  int unsigned                live_pages;
  logic [pfl_pkg::CNT_W-1:0]  alloc_count;
  logic [pfl_pkg::CNT_W-1:0]  free_count;
  int                         full_replies;
  int                         refused_frees;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Put the cells of a page from offset first up on the list, highest offset ending at the head
  function automatic void push_page(int unsigned pg, int unsigned first);
    int unsigned a;
    for (int unsigned off = first; off < PAGE_CELLS; off++) begin
      a = pg * PAGE_CELLS + off;
      shadow_free[a] = 1'b1;
      shadow_link[a] = chain_dry ? '0 : head_cell;
      head_cell      = pfl_pkg::ADDR_W'(a);
      chain_dry      = 1'b0;
    end
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < ALL_CELLS; i++) begin
      shadow_free[i] = 1'b0;
      shadow_link[i] = '0;
      shadow_tag[i]  = '0;
    end
    head_cell     = '0;
    chain_dry     = 1'b1;
    alloc_count   = '0;
    free_count    = '0;
    full_replies  = 0;
    refused_frees = 0;
    push_page(0, pfl_pkg::PINNED_CELLS);
    live_pages = 1;
  endfunction

  // Apply one request to the shadow state and return the result it owes
  function automatic cell_result_t compute_cell_result(cell_request_t rq);
    cell_result_t r;
    logic [pfl_pkg::ADDR_W-1:0] a;
    r        = '0;
    r.status = pfl_pkg::ST_OK;
    if (rq.op == pfl_pkg::OP_ALLOC) begin
      // lazy page bring-up on an empty list
      if (chain_dry && live_pages < PAGES) begin
        push_page(live_pages, 0);
        live_pages++;
      end
      if (chain_dry) begin
        r.status = pfl_pkg::ST_FULL;
        full_replies++;
      end else begin
        a              = head_cell;
        shadow_free[a] = 1'b0;
        shadow_tag[a]  = rq.tag;
        if (shadow_link[a] == '0) chain_dry = 1'b1;
        else head_cell = shadow_link[a];
        alloc_count++;
        r.addr = a;
      end
    end else begin
      r.addr = rq.addr;
      if (rq.addr < pfl_pkg::PINNED_CELLS) begin
        r.status = pfl_pkg::ST_PINNED;
      end else if (rq.addr >= ALL_CELLS || rq.addr / PAGE_CELLS >= live_pages ||
                   shadow_free[rq.addr]) begin
        r.status = pfl_pkg::ST_NOT_HELD;
        refused_frees++;
      end else begin
        r.tag                 = shadow_tag[rq.addr];
        shadow_free[rq.addr]  = 1'b1;
        shadow_link[rq.addr]  = chain_dry ? '0 : head_cell;
        head_cell             = rq.addr;
        chain_dry             = 1'b0;
        free_count++;
      end
    end
    r.pages  = pfl_pkg::PAGES_W'(live_pages);
    r.allocs = alloc_count;
    r.frees  = free_count;
    return r;
  endfunction

  // Random cell that is currently handed out; falls back to the last cell tried
  function automatic logic [pfl_pkg::ADDR_W-1:0] pick_held_cell();
    logic [pfl_pkg::ADDR_W-1:0] c;
    c = pfl_pkg::ADDR_W'($urandom);
    for (int k = 0; k < 32; k++) begin
      c = pfl_pkg::ADDR_W'($urandom_range(live_pages * PAGE_CELLS - 1,
                                          pfl_pkg::PINNED_CELLS));
      if (!shadow_free[c]) return c;
    end
    return c;
  endfunction

  function automatic void push_request(logic op, logic [pfl_pkg::TAG_W-1:0] tag,
                                       logic [pfl_pkg::ADDR_W-1:0] addr);
    cell_request_t rq;
    rq.op   = op;
    rq.tag  = tag;
    rq.addr = addr;
    pending_requests.push_back(rq);
  endfunction

  // Allocates with alloc_pct chance; frees are mostly of held cells, some pinned and arbitrary addresses as noise
  function automatic void push_random_request(int alloc_pct);
    int unsigned pick;
    logic [pfl_pkg::ADDR_W-1:0] target;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      push_request(pfl_pkg::OP_ALLOC, $urandom, pfl_pkg::ADDR_W'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 80) target = pick_held_cell();
      else if (pick < 86)
        target = pfl_pkg::ADDR_W'($urandom_range(pfl_pkg::PINNED_CELLS - 1));
      else target = pfl_pkg::ADDR_W'($urandom);
      push_request(pfl_pkg::OP_FREE, $urandom, target);
    end
  endfunction

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 53;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 53;
      end
      default: begin
        send_gap_pct = 32;
        stall_pct    = 32;
      end
    endcase
  endfunction

  // Wait until every queued request is sent and every owed result is back
  task automatic await_results();
    do @(negedge clk);
    while (in_valid || pending_requests.size() != 0 || cell_results_due.size() != 0);
  endtask

  task automatic run_batch(int alloc_pct);
    set_idling(idle_mode_t'((batch_no / 4) % 4));
    for (int i = 0; i < BATCH; i++) push_random_request(alloc_pct);
    batch_no++;
    do @(negedge clk);
    while (pending_requests.size() != 0);
    if (batch_no % 7 == 0) await_results();
  endtask

  task automatic flag_mismatch(input string what, input logic [pfl_pkg::TAG_W-1:0] got,
                               input logic [pfl_pkg::TAG_W-1:0] want);
    mismatches++;
    $display("%0t: result %0d: %s got %0h, want %0h", $realtime, results_seen, what,
             got, want);
  endtask

  task automatic check_cell_result();
    cell_result_t want;
    if (cell_results_due.size() == 0) begin
      flag_mismatch("result with nothing owed, cell_address", out_cell_address, '0);
    end else begin
      want = cell_results_due.pop_front();
      results_seen++;
      if (out_cell_address !== want.addr)
        flag_mismatch("cell_address", out_cell_address, want.addr);
      if (out_status !== want.status)
        flag_mismatch("status", out_status, want.status);
      if (out_freed_tag !== want.tag)
        flag_mismatch("freed_tag", out_freed_tag, want.tag);
      if (out_pages_in_use !== want.pages)
        flag_mismatch("pages_in_use", out_pages_in_use, want.pages);
      if (out_allocated_total !== want.allocs)
        flag_mismatch("allocated_total", out_allocated_total, want.allocs);
      if (out_freed_total !== want.frees)
        flag_mismatch("freed_total", out_freed_total, want.frees);
    end
  endtask

  // Driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        next_request.op   = in_op;
        next_request.tag  = in_cell_tag_in;
        next_request.addr = in_cell_to_free;
        cell_results_due.push_back(compute_cell_result(next_request));
        beats_sent++;
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_request = pending_requests.pop_front();
        in_valid        <= 1'b1;
        in_op           <= next_request.op;
        in_cell_tag_in  <= next_request.tag;
        in_cell_to_free <= next_request.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result beat, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_cell_result();
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_shadow();
    set_idling(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tag extremes, pinned cells, unbrought pages, double free, LIFO reuse
    push_request(pfl_pkg::OP_ALLOC, 32'h0000_0000, 11'h000);
    push_request(pfl_pkg::OP_ALLOC, 32'hFFFF_FFFF, 11'h7FF);
    push_request(pfl_pkg::OP_ALLOC, 32'h5A5A_5A5A, 11'h555);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd0);
    push_request(pfl_pkg::OP_FREE,  32'hFFFF_FFFF, 11'd1);
    push_request(pfl_pkg::OP_FREE,  32'hFFFF_FFFF, 11'd2047);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd256);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd2);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd254);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd254);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd255);
    push_request(pfl_pkg::OP_ALLOC, 32'h8000_0001, 11'h000);
    push_request(pfl_pkg::OP_ALLOC, 32'h7FFF_FFFE, 11'h000);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd253);
    push_request(pfl_pkg::OP_FREE,  32'h0000_0000, 11'd1023);
    push_request(pfl_pkg::OP_ALLOC, 32'h0000_0001, 11'h000);
    await_results();

    // Mixed traffic, then fill every page until the list runs dry
    for (int i = 0; i < 5; i++) run_batch(65);
    while (full_replies < 8 && batch_no < 200) run_batch(98);
    // Drain back down, then mixed traffic on a fully paged heap
    for (int i = 0; i < 4; i++) run_batch(25);
    for (int i = 0; i < 4; i++) run_batch(55);
    await_results();
    repeat (10) @(negedge clk);

    if (cell_results_due.size() != 0)
      flag_mismatch("results still owed", cell_results_due.size(), '0);
    $display("run: %0d requests, %0d results checked, %0d pages up", beats_sent,
             results_seen, live_pages);
    $display("run: %0d allocations, %0d good frees, %0d out of space, %0d refused frees",
             alloc_count, free_count, full_replies, refused_frees);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
